>>> src/prb_pkg.sv
package prb_pkg;

    localparam int PTS_W     = 64;
    localparam int DUR_W     = 32;
    localparam int EPOCH_W   = 8;
    localparam int REG_W     = 32;
    localparam int REG_IDX_W = 2;
    localparam int TDATA_W   = 112;
    localparam int RES_CNT_W = 5;

    localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 5'd16;

    // Most negative timestamp marks "unset"
    localparam logic [PTS_W-1:0] PTS_NONE = {1'b1, {(PTS_W-1){1'b0}}};

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_GAP_MIN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAP_MAX = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRUST   = 2'd2;

    localparam logic [REG_W-1:0] GAP_MIN_RST = 32'd1000;
    localparam logic [REG_W-1:0] GAP_MAX_RST = 32'd1000000;
    localparam logic [REG_W-1:0] TRUST_RST   = 32'd10000;

    localparam logic [DUR_W-1:0] DUR_SAT = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_REL_RD,
        ST_REL_CMP,
        ST_REL_DUR,
        ST_PUSH,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [PTS_W-1:0]   pts;
        logic [DUR_W-1:0]   dur;
        logic [EPOCH_W-1:0] epoch;
        logic               drive;
    } t_entry;

    typedef struct packed {
        logic               kind;
        logic [PTS_W-1:0]   pts;
        logic [DUR_W-1:0]   dur;
        logic [EPOCH_W-1:0] epoch;
        logic               drive;
        logic               deliver;
    } t_result;

endpackage

>>> src/pts_reorder_buffer.sv
// Channel  Dir  Word layout (low bit first)                                  Marks
// s_axis   in   tdata: pts[63:0] duration[95:64] epoch[103:96] drive[104]    tuser: command
//               skip[105] zero[111:106]
// m_axis   out  tdata: pts[63:0] duration[95:64] epoch[103:96] drive[104]    tuser: kind
//               deliver[105] zero[111:106]                                   tlast: last
// cfg      in   i_cfg_wr_en, i_cfg_index (0 gap_min, 1 gap_max, 2 trust), i_cfg_data
//
// Input: a flush leaves tready high; a stored frame drops tready while every stored
// entry above its pts shifts up and frames are released, a skipped or dropped frame
// while frames are released, all paced by the single memory read port.
// Reset (i_rst_n low, synchronous) empties the store, unsets all timestamps, zeroes
// the estimate and reloads the register defaults; entry contents are kept.
// Stalls: once a result waits behind the output register, m_axis stalls halt the sequencer.
module pts_reorder_buffer
    import prb_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave word
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [TDATA_W-1:0]   i_s_tdata,   // pts, frame_duration, epoch, lead_clock, skip
    input  logic                 i_s_tuser,   // command
    // master word
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDATA_W-1:0]   o_m_tdata,   // out_pts, out_duration, out_epoch,
                                              // out_lead_clock, deliver
    output logic                 o_m_tuser,   // kind
    output logic                 o_m_tlast,   // last
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW:0]   DEPTH_W = DEPTH[IW:0];
    localparam logic [CW-1:0] DEPTH_C = DEPTH[CW-1:0];

    // Physical slot of logical position k, counted from the head of the ring
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] base,
                                             input logic [CW-1:0] k);
        logic [IW:0] kx;
        logic [IW:0] sum;
        kx  = (IW+1)'(k);
        sum = {1'b0, base} + kx;
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    // Entry memory: one write port, one registered read port
    t_entry r_mem [DEPTH];
    t_entry r_rdata;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [IW-1:0]  mem_raddr;
    t_entry         mem_wdata;

    t_state r_state, n_state;
    logic [IW-1:0]        r_head,  n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx,   n_idx;
    logic [RES_CNT_W-1:0] r_nres,  n_nres;
    logic [PTS_W-1:0]     r_largest, n_largest;
    logic [PTS_W-1:0]     r_mark,    n_mark;
    logic [PTS_W-1:0]     r_prev,    n_prev;
    logic [DUR_W-1:0]     r_est,     n_est;
    logic [REG_W-1:0]     r_gap_min, r_gap_max, r_trust;

    t_entry           r_in,  n_in;
    t_entry           r_cur, n_cur;
    logic [PTS_W-1:0] r_gap, n_gap;
    logic             r_gap_ok, n_gap_ok;
    t_result          r_res, n_res;
    t_result          r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    t_result          r_out, n_out;
    logic             r_out_last, n_out_last;
    logic             r_out_v, n_out_v;

    logic             out_free;
    logic             s_accept;
    logic             in_skip;
    logic             gap_hit;
    logic [DUR_W-1:0] est_new;
    logic [DUR_W-1:0] chosen;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_v || i_m_tready;
    assign in_skip    = i_s_tdata[105];

    // Duration choice for the entry under release
    always_comb begin
        gap_hit = r_gap_ok && (r_gap > {32'd0, r_gap_min}) && (r_gap < {32'd0, r_gap_max});
        if (!gap_hit) begin
            est_new = r_est;
        end else if (r_gap[PTS_W-1:DUR_W-1] != '0) begin
            est_new = DUR_SAT;
        end else begin
            est_new = r_gap[DUR_W-1:0];
        end
        if ($signed({r_cur.dur[DUR_W-1], r_cur.dur}) > $signed({1'b0, r_trust})) begin
            chosen = r_cur.dur;
        end else begin
            chosen = est_new;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_nres     = r_nres;
        n_largest  = r_largest;
        n_mark     = r_mark;
        n_prev     = r_prev;
        n_est      = r_est;
        n_in       = r_in;
        n_cur      = r_cur;
        n_gap      = r_gap;
        n_gap_ok   = r_gap_ok;
        n_res      = r_res;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_v    = r_out_v;
        mem_we     = 1'b0;
        mem_waddr  = r_head;
        mem_raddr  = r_head;
        mem_wdata  = r_in;

        // drop the output word once taken
        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_in.pts   = i_s_tdata[63:0];
                    n_in.dur   = i_s_tdata[95:64];
                    n_in.epoch = i_s_tdata[103:96];
                    n_in.drive = i_s_tdata[104];
                    n_nres     = '0;
                    if (i_s_tuser == CMD_FLUSH) begin
                        n_count   = '0;
                        n_largest = PTS_NONE;
                        n_mark    = PTS_NONE;
                        n_prev    = PTS_NONE;
                    end else if (in_skip) begin
                        n_state = ST_REL_RD;
                    end else if (r_count == DEPTH_C) begin
                        // store full: flag the incoming frame
                        n_pend.kind    = KIND_DROP;
                        n_pend.pts     = i_s_tdata[63:0];
                        n_pend.dur     = '0;
                        n_pend.epoch   = i_s_tdata[103:96];
                        n_pend.drive   = i_s_tdata[104];
                        n_pend.deliver = 1'b0;
                        n_pend_v       = 1'b1;
                        n_nres         = RES_CNT_W'(1);
                        n_state        = ST_REL_RD;
                    end else begin
                        n_idx   = r_count;
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                if (r_idx == '0) begin
                    n_state = ST_INS_PUT;
                end else begin
                    mem_raddr = f_slot(r_head, r_idx - CW'(1));
                    n_state   = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                // shift larger entries up by one, ties stay below the new frame
                if ($signed(r_rdata.pts) > $signed(r_in.pts)) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_slot(r_head, r_idx);
                    mem_wdata = r_rdata;
                    n_idx     = r_idx - CW'(1);
                    n_state   = ST_INS_RD;
                end else begin
                    n_state = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = f_slot(r_head, r_idx);
                mem_wdata = r_in;
                n_count   = r_count + CW'(1);
                if (r_largest != PTS_NONE) begin
                    if ($signed(r_in.pts) > $signed(r_largest)) begin
                        n_mark    = r_largest;
                        n_largest = r_in.pts;
                    end
                end else begin
                    n_largest = r_in.pts;
                end
                n_state = ST_REL_RD;
            end
            ST_REL_RD: begin
                if (r_mark == PTS_NONE || r_count == '0 || r_nres == MAX_RESULTS) begin
                    n_state = ST_FINISH;
                end else begin
                    mem_raddr = r_head;
                    n_state   = ST_REL_CMP;
                end
            end
            ST_REL_CMP: begin
                if ($signed(r_rdata.pts) <= $signed(r_mark)) begin
                    n_cur    = r_rdata;
                    n_gap    = r_rdata.pts - r_prev;
                    n_gap_ok = (r_prev != PTS_NONE) && (r_rdata.pts != PTS_NONE)
                               && ($signed(r_rdata.pts) > $signed(r_prev));
                    n_state  = ST_REL_DUR;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_REL_DUR: begin
                n_est         = est_new;
                n_prev        = r_cur.pts;
                n_res.kind    = KIND_RELEASE;
                n_res.pts     = r_cur.pts;
                n_res.dur     = chosen;
                n_res.epoch   = r_cur.epoch;
                n_res.drive   = r_cur.drive;
                n_res.deliver = $signed(chosen) > 0;
                n_head        = f_slot(r_head, CW'(1));
                n_count       = r_count - CW'(1);
                n_nres        = r_nres + RES_CNT_W'(1);
                n_state       = ST_PUSH;
            end
            ST_PUSH: begin
                // hold one result back so the last one can carry tlast
                if (!r_pend_v) begin
                    n_pend   = r_res;
                    n_pend_v = 1'b1;
                    n_state  = ST_REL_RD;
                end else if (out_free) begin
                    n_out      = r_pend;
                    n_out_last = 1'b0;
                    n_out_v    = 1'b1;
                    n_pend     = r_res;
                    n_state    = ST_REL_RD;
                end
            end
            ST_FINISH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_nres    <= '0;
            r_largest <= PTS_NONE;
            r_mark    <= PTS_NONE;
            r_prev    <= PTS_NONE;
            r_est     <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_gap_min <= GAP_MIN_RST;
            r_gap_max <= GAP_MAX_RST;
            r_trust   <= TRUST_RST;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_nres    <= n_nres;
            r_largest <= n_largest;
            r_mark    <= n_mark;
            r_prev    <= n_prev;
            r_est     <= n_est;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_GAP_MIN: r_gap_min <= i_cfg_data;
                    REG_GAP_MAX: r_gap_max <= i_cfg_data;
                    REG_TRUST:   r_trust   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_cur      <= n_cur;
        r_gap      <= n_gap;
        r_gap_ok   <= n_gap_ok;
        r_res      <= n_res;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'd0, r_out.deliver, r_out.drive, r_out.epoch,
                         r_out.dur, r_out.pts};

endmodule
